// ===== src/binary_to_decimal_ascii_defines.svh =====
// Assertion macros used by the checker file of the decimal text converter.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bda_pkg.sv =====
`default_nettype none

package bda_pkg;

    localparam int unsigned DIGIT_COUNT = 10;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned WIDE_W      = 34;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd9;
    localparam logic [IDX_W-1:0] DONE_IDX = 4'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    typedef enum logic [1:0] {
        SEL_DIGIT = 2'd0,
        SEL_POINT = 2'd1,
        SEL_ZERO  = 2'd2
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      push;
        char_sel_t sel;
        logic      last;
    } bda_cmd_t;

    typedef struct packed {
        logic out_free;
        logic zero;
        logic point_here;
        logic last_digit;
        logic digits_done;
    } bda_status_t;

    // Decimal weight of the digit at a given place, most significant place first.
    function automatic logic [WIDE_W-1:0] dec_weight(input logic [IDX_W-1:0] idx);
        logic [WIDE_W-1:0] w;
        case (idx)
            4'd0:    w = 34'd1000000000;
            4'd1:    w = 34'd100000000;
            4'd2:    w = 34'd10000000;
            4'd3:    w = 34'd1000000;
            4'd4:    w = 34'd100000;
            4'd5:    w = 34'd10000;
            4'd6:    w = 34'd1000;
            4'd7:    w = 34'd100;
            4'd8:    w = 34'd10;
            4'd9:    w = 34'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Place of the leading digit; zero starts at the units place.
    function automatic logic [IDX_W-1:0] lead_index(input logic [31:0] value);
        logic [IDX_W-1:0] idx;
        idx = LAST_IDX;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            if ({2'b00, value} >= dec_weight(IDX_W'(i))) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== src/bda_in_if.sv =====
`default_nettype none

interface bda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        point_enable;
    logic [3:0]  point_position;

    modport source (output valid, output value, output point_enable,
                     output point_position, input ready);
    modport sink   (input valid, input value, input point_enable,
                     input point_position, output ready);
endinterface

`default_nettype wire

// ===== src/bda_out_if.sv =====
`default_nettype none

interface bda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== src/bda_ctrl.sv =====
`default_nettype none

module bda_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bda_pkg::bda_status_t status,
    output bda_pkg::bda_cmd_t         cmd
);
    import bda_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIGIT = 4'b0010,
        ST_POINT = 4'b0100,
        ST_TAIL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.push   = 1'b0;
        cmd.sel    = SEL_DIGIT;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = status.last_digit && !status.point_here;
                    if (status.point_here)
                    begin
                        state_next = ST_POINT;
                    end
                    else if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POINT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_POINT;
                    cmd.last = status.digits_done && !status.zero;
                    if (!status.digits_done)
                    begin
                        state_next = ST_DIGIT;
                    end
                    else if (status.zero)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_ZERO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/bda_datapath.sv =====
`default_nettype none

module bda_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       value,
    input  wire logic              point_enable,
    input  wire logic [3:0]        point_position,
    input  wire bda_pkg::bda_cmd_t cmd,
    output bda_pkg::bda_status_t   status,
    bda_out_if.source              text
);
    import bda_pkg::*;

    logic [31:0]      rem_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             pe_reg;
    logic [3:0]       pos_reg;
    logic             zero_reg;
    logic             out_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [WIDE_W-1:0] weight;
    logic [WIDE_W-1:0] multiple [0:DIGIT_COUNT-1];
    logic [3:0]        digit;
    logic [31:0]       rem_next;
    logic [7:0]        char_next;

    // One decimal digit per step: compare the remainder against all nine
    // multiples of the current weight and take the largest that fits.
    always_comb
    begin
        weight = dec_weight(idx_reg);
        digit  = 4'd0;
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            multiple[k] = weight * WIDE_W'(k);
        end
        for (int k = 1; k < DIGIT_COUNT; k++)
        begin
            if ({2'b00, rem_reg} >= multiple[k])
            begin
                digit = 4'(k);
            end
        end
        rem_next = rem_reg - multiple[digit][31:0];
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_DIGIT: char_next = CHAR_ZERO + {4'b0000, digit};
            SEL_POINT: char_next = CHAR_POINT;
            SEL_ZERO:  char_next = CHAR_ZERO;
            default:   char_next = CHAR_ZERO;
        endcase
    end

    assign status.out_free    = !out_valid_reg || text.ready;
    assign status.zero        = zero_reg;
    assign status.last_digit  = (idx_reg == LAST_IDX);
    assign status.digits_done = (idx_reg == DONE_IDX);
    assign status.point_here  = pe_reg &&
        (zero_reg || ((pos_reg <= LAST_IDX) && (idx_reg == LAST_IDX - pos_reg)));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= value;
            idx_reg  <= lead_index(value);
            pe_reg   <= point_enable;
            pos_reg  <= point_position;
            zero_reg <= (value == 32'd0);
        end
        else if (cmd.push && (cmd.sel == SEL_DIGIT))
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_reg + 4'd1;
        end
        if (cmd.push)
        begin
            char_reg <= char_next;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (text.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = char_reg;
    assign text.last_char = last_reg;

endmodule

`default_nettype wire

// ===== src/binary_to_decimal_ascii.sv =====
`default_nettype none

// Binary to decimal text converter.
// The number channel takes one transaction per conversion: a 32-bit unsigned
// value, a point enable and a point position (digits after the point).
// The text channel returns the decimal characters, most significant first,
// one transaction per character, with leading zeros suppressed. The final
// character of each conversion carries last_char. A zero value gives "0",
// or "0.0" when the point is enabled. A point that would fall above the
// leading digit is dropped; position 0 gives a trailing point.
// The number is first loaded into the remainder and place registers; the
// first character is then registered in the output register. One character
// leaves per cycle while the receiver is ready, 1 to 11 per conversion. The
// digit unit produces one decimal digit per cycle when the output is free,
// from parallel compares against the nine multiples of the current weight.
// The number channel is ready only between conversions. When the receiver
// stalls, the output register holds its character and the sequencer waits;
// nothing is lost or repeated. Reset clears the sequencer and the output
// valid flag; the datapath registers are not reset.
module binary_to_decimal_ascii (
    input  wire logic clk,
    input  wire logic rst_n,
    bda_in_if.sink    number,
    bda_out_if.source text
);
    import bda_pkg::*;

    bda_cmd_t    cmd;
    bda_status_t status;

    // Sequencer: walks the digit, point and trailing-zero steps.
    bda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Remainder, digit extraction and the output register.
    bda_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .value          (number.value),
        .point_enable   (number.point_enable),
        .point_position (number.point_position),
        .cmd            (cmd),
        .status         (status),
        .text           (text)
    );

endmodule

`default_nettype wire

// ===== src/bda_checker.sv =====
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module bda_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] text_char,
    input wire logic       last_char
);
    import bda_pkg::*;

    // A new conversion is never taken in the cycle right after one starts.
    `BDA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // While a character other than the last is pending, no number is taken.
    `BDA_ASSERT_SAME(a_no_overlap, out_valid && !last_char, !in_ready, "overlapping conversion")

    // Only digits and the point are ever emitted.
    `BDA_ASSERT_SAME(a_char_set, out_valid, ((text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE)) || (text_char == CHAR_POINT), "bad character")

    // A stalled character holds.
    `BDA_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(text_char) && $stable(last_char), "stalled output changed")

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .text_char (text.text_char),
    .last_char (text.last_char)
);

`default_nettype wire
